/* hdl/albm_pkg.sv */
// Package for the audio level LED bar meter: constants, state and command types.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package albm_pkg;
    localparam int NUM_LEDS = 60;
    localparam int FRAME_MAX = 1024;
    localparam int LED_W = 6;
    localparam int CNT_W = 11;
    localparam int SUM_W = 26;
    localparam int LVL_W = 24;
    localparam int COL_W = 26;
    localparam int DIV_W = 41;
    localparam int DIV_CNT_W = 6;
    localparam logic [3:0] CFG_THRESH = 4'd0;
    localparam logic [3:0] CFG_SPEED  = 4'd1;
    localparam logic [3:0] CFG_DECAY  = 4'd2;
    localparam logic [3:0] CFG_RED    = 4'd3;
    localparam logic [3:0] CFG_GREEN  = 4'd4;
    localparam logic [3:0] CFG_BLUE   = 4'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MEAN_START, ST_MEAN_WAIT, ST_LEVEL, ST_DECAY, ST_PEAK,
        ST_HGT_WAIT, ST_STEP_START, ST_STEP_WAIT, ST_WALK, ST_EMIT
    } state_t;

    typedef struct packed {
        logic accum;
        logic clear_frame;
        logic div_mean;
        logic level;
        logic decay;
        logic peak;
        logic div_height;
        logic div_step;
        logic walk;
        logic emit_load;
        logic emit_next;
        logic zero_peak;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic quiet;
        logic need_div;
        logic last_led;
    } stat_t;
endpackage

/* hdl/audio_level_led_bar_meter_top.sv */
// Audio level LED bar meter: input samples on s_axis, configuration on cfg_,
// and one result per LED on m_axis. Top level; depends on albm_pkg.
//
// Usage:
//  - s_tdata[15:0] is a signed sample; s_tuser flags the frame's last sample.
//  - s_tready stays high after a sample without the frame flag.
//  - At the frame end the block runs a shared divider up to three times
//    (mean, bar height, color step); the height and step divisions are
//    skipped when not needed. Then NUM_LEDS requests are issued, one per
//    cycle while m_tready is high.
//  - A frame that is silent now and in the two previous frames emits nothing;
//    s_tready returns once the mean division ends.
//  - s_tready is low from the frame end until the last LED request is taken.
//  - A stalled receiver holds the current request; nothing is lost.
//  - Reset restores the register defaults, clears the level history and peak
//    and sets the color to full red.
//  - cfg_index picks the register; writes are always accepted.
`timescale 1ns / 1ps
module audio_level_led_bar_meter_top import albm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample
    input  logic        s_tuser,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // led_index, red, green, blue (from bit 0)
    output logic        m_tlast,   // last_led
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    cmd_t cmd;
    stat_t stat;
    logic [LED_W-1:0] led_index;
    logic [7:0] red, green, blue;

    assign cfg_ready = 1'b1;

    albm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_tvalid & s_tready), .in_last(s_tuser),
        .out_fire(m_tvalid & m_tready), .stat(stat),
        .in_ready(s_tready), .out_valid(m_tvalid), .cmd(cmd)
    );

    albm_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .sample(s_tdata), .cfg_fire(cfg_valid & cfg_ready),
        .cfg_index(cfg_index), .cfg_value(cfg_data),
        .led_index(led_index), .red(red), .green(green), .blue(blue),
        .last_led(m_tlast)
    );

    assign m_tdata = {2'b0, blue, green, red, led_index};
endmodule

/* hdl/albm_ctrl.sv */
// Controller state machine for the meter: sequences the frame-end work.
// Depends on albm_pkg.
`timescale 1ns / 1ps
module albm_ctrl import albm_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_fire,
    input  logic  in_last,
    input  logic  out_fire,
    input  stat_t stat,
    output logic  in_ready,
    output logic  out_valid,
    output cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.accum = 1'b1;
                    if (in_last) state_next = ST_MEAN_START;
                end
            end
            ST_MEAN_START: begin
                cmd.div_mean = 1'b1;
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (!stat.div_busy) begin
                    cmd.clear_frame = 1'b1;
                    if (stat.quiet) begin
                        cmd.zero_peak = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_LEVEL;
                    end
                end
            end
            ST_LEVEL: begin
                cmd.level = 1'b1;
                state_next = ST_DECAY;
            end
            ST_DECAY: begin
                cmd.decay = 1'b1;
                state_next = ST_PEAK;
            end
            ST_PEAK: begin
                cmd.peak = 1'b1;
                if (stat.need_div) begin
                    cmd.div_height = 1'b1;
                    state_next = ST_HGT_WAIT;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_HGT_WAIT: if (!stat.div_busy) state_next = ST_STEP_START;
            ST_STEP_START: begin
                cmd.div_step = 1'b1;
                state_next = ST_STEP_WAIT;
            end
            ST_STEP_WAIT: if (!stat.div_busy) state_next = ST_WALK;
            ST_WALK: begin
                cmd.walk = 1'b1;
                cmd.emit_load = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                out_valid = 1'b1;
                if (out_fire) begin
                    cmd.emit_next = 1'b1;
                    if (stat.last_led) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

/* hdl/albm_dp.sv */
// Datapath for the meter: accumulators, level and peak registers, a shared
// restoring divider, color walk and LED output counter. Depends on albm_pkg.
`timescale 1ns / 1ps
module albm_dp import albm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic signed [15:0]  sample,
    input  logic                cfg_fire,
    input  logic [3:0]          cfg_index,
    input  logic [15:0]         cfg_value,
    output logic [LED_W-1:0]    led_index,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic                last_led
);
    logic [14:0] thresh_reg;
    logic [15:0] speed_reg, decay_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [LVL_W-1:0] prev_reg, older_reg, peak_reg, mean_reg;
    logic [LVL_W-1:0] level_reg;
    logic signed [COL_W-1:0] cr_reg, cg_reg, cb_reg;
    logic [LED_W-1:0] height_reg, idx_reg;
    logic [16:0] step_reg;
    logic silent_reg;
    logic [7:0] or_reg, og_reg, ob_reg;

    // Restoring divider, one quotient bit per cycle.
    logic [DIV_W-1:0] dq_reg;
    logic [LVL_W:0] dd_reg;
    logic [LVL_W:0] drem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic dbusy_reg;
    logic [LVL_W+1:0] dtrial;
    logic [DIV_W-1:0] dvd_next;
    logic [LVL_W:0] dvs_next;
    logic dstart;

    logic [15:0] mag;
    logic [LVL_W+2:0] lvl_sum;
    logic [LVL_W-1:0] lvl_sat;
    logic [LVL_W+15:0] dprod;
    logic [15:0] dec;
    logic [LVL_W-1:0] peak_dec;
    logic [LVL_W-1:0] peak_max;
    logic [LVL_W+15:0] sprod;

    assign mag = sample[15] ? 16'(-sample) : sample;
    assign dtrial = {drem_reg, dq_reg[DIV_W-1]} - {1'b0, dd_reg};
    assign dstart = cmd.div_mean | cmd.div_height | cmd.div_step;
    assign lvl_sum = {2'b0, mean_reg, 1'b0} + 27'(3 * {3'b0, prev_reg}) + 27'd2;
    assign lvl_sat = lvl_sum[LVL_W+2] ? {LVL_W{1'b1}} : lvl_sum[LVL_W+1:2];
    assign dprod = decay_reg * level_reg + 40'(1 << 23);
    assign dec = dprod[LVL_W+15:24];
    assign peak_dec = ({8'b0, dec} >= peak_reg) ? '0 : peak_reg - {8'b0, dec};
    // The height division starts in the same cycle that raises the peak.
    assign peak_max = (level_reg > peak_reg) ? level_reg : peak_reg;
    assign sprod = level_reg * speed_reg;

    always_comb begin
        dvd_next = '0;
        dvs_next = '0;
        if (cmd.div_mean) begin
            dvd_next = DIV_W'({sum_reg, 8'b0});
            dvs_next = (cnt_reg == '0) ? 25'd1 : 25'(cnt_reg);
        end else if (cmd.div_height) begin
            dvd_next = DIV_W'(NUM_LEDS * 32'(level_reg));
            dvs_next = {1'b0, peak_max};
        end else begin
            dvd_next = {sprod, 1'b0} + DIV_W'(peak_reg);
            dvs_next = {peak_reg, 1'b0};
        end
    end

    function automatic logic [7:0] col_out(input logic signed [COL_W-1:0] v);
        logic [COL_W-16:0] r;
        r = 11'((v + 26'sd32768) >>> 16);
        if (v < 0) return 8'd0;
        if (v > 26'sd16744447) return 8'd255;
        return r[7:0];
    endfunction

    function automatic logic signed [COL_W-1:0] sat_add(
        input logic signed [COL_W-1:0] a, input logic signed [17:0] b);
        logic signed [COL_W:0] s;
        s = 27'(a) + 27'(b);
        if (s > 27'sd33554431) return 26'sd33554431;
        if (s < -27'sd33554432) return {1'b1, {(COL_W-1){1'b0}}};
        return s[COL_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        logic signed [COL_W-1:0] r, g, b;
        logic signed [17:0] st;
        if (!aresetn) begin
            thresh_reg <= 15'd328; speed_reg <= 16'd32768; decay_reg <= 16'd1678;
            sum_reg <= '0; cnt_reg <= '0;
            prev_reg <= '0; older_reg <= '0; peak_reg <= '0;
            cr_reg <= 26'(255 << 16); cg_reg <= '0; cb_reg <= '0;
            dbusy_reg <= 1'b0; idx_reg <= '0;
        end else begin
            if (cfg_fire) begin
                unique case (cfg_index)
                    CFG_THRESH: thresh_reg <= cfg_value[14:0];
                    CFG_SPEED:  speed_reg <= cfg_value;
                    CFG_DECAY:  decay_reg <= cfg_value;
                    CFG_RED:    cr_reg <= 26'({cfg_value[7:0], 16'b0});
                    CFG_GREEN:  cg_reg <= 26'({cfg_value[7:0], 16'b0});
                    CFG_BLUE:   cb_reg <= 26'({cfg_value[7:0], 16'b0});
                    default: ;
                endcase
            end
            if (cmd.accum && cnt_reg < CNT_W'(FRAME_MAX)) begin
                sum_reg <= sum_reg + SUM_W'(mag);
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (dstart) begin
                dq_reg <= dvd_next; dd_reg <= dvs_next;
                drem_reg <= '0; dcnt_reg <= '0; dbusy_reg <= 1'b1;
            end else if (dbusy_reg) begin
                if (!dtrial[LVL_W+1]) drem_reg <= dtrial[LVL_W:0];
                else drem_reg <= {drem_reg[LVL_W-1:0], dq_reg[DIV_W-1]};
                dq_reg <= {dq_reg[DIV_W-2:0], ~dtrial[LVL_W+1]};
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_CNT_W'(DIV_W - 1)) dbusy_reg <= 1'b0;
            end
            if (cmd.clear_frame) begin
                sum_reg <= '0; cnt_reg <= '0;
                mean_reg <= dq_reg[LVL_W-1:0];
            end
            if (cmd.zero_peak) peak_reg <= '0;
            if (cmd.level) begin
                level_reg <= lvl_sat;
                older_reg <= prev_reg;
                prev_reg <= lvl_sat;
            end
            if (cmd.decay) begin
                peak_reg <= peak_dec;
                silent_reg <= level_reg < {1'b0, thresh_reg, 8'b0};
            end
            if (cmd.peak) begin
                height_reg <= '0;
                if (silent_reg) begin
                    step_reg <= 17'((32'(speed_reg) * 655 + 32768) >> 16);
                end else begin
                    step_reg <= '0;
                    if (level_reg > peak_reg) peak_reg <= level_reg;
                end
            end
            if (cmd.div_step) height_reg <= dq_reg[LED_W-1:0];
            if (cmd.walk) begin
                if (!silent_reg && (peak_reg != '0))
                    st = 18'(dq_reg[16:0]);
                else st = 18'(step_reg);
                r = cr_reg; g = cg_reg; b = cb_reg;
                if (r > 0 && b <= 0) begin r = sat_add(r, -st); g = sat_add(g, st); end
                if (g > 0 && r <= 0) begin g = sat_add(g, -st); b = sat_add(b, st); end
                if (b > 0 && g <= 0) begin b = sat_add(b, -st); r = sat_add(r, st); end
                cr_reg <= r; cg_reg <= g; cb_reg <= b;
                or_reg <= col_out(r); og_reg <= col_out(g); ob_reg <= col_out(b);
            end
            if (cmd.emit_load) idx_reg <= '0;
            else if (cmd.emit_next) idx_reg <= idx_reg + 1'b1;
        end
    end

    assign stat.div_busy = dbusy_reg;
    assign stat.quiet = (dq_reg[LVL_W-1:0] == '0) && (prev_reg == '0) && (older_reg == '0);
    assign stat.need_div = !silent_reg && ((peak_reg != '0) || (level_reg != '0));
    assign stat.last_led = (idx_reg == LED_W'(NUM_LEDS - 1));

    assign led_index = idx_reg;
    assign last_led = stat.last_led;
    assign red   = (idx_reg < height_reg) ? or_reg : 8'd0;
    assign green = (idx_reg < height_reg) ? og_reg : 8'd0;
    assign blue  = (idx_reg < height_reg) ? ob_reg : 8'd0;
endmodule

/* hdl/albm_checker.sv */
// Port-level checker for the meter top level, with its bind statement.
// Depends on albm_pkg.
`timescale 1ns / 1ps
module albm_checker import albm_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken during output");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[5:0] == 6'(NUM_LEDS - 1))
        else $error("last flag on wrong LED");
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid &&
        m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1)
        else $error("LED index skipped");
endmodule

bind audio_level_led_bar_meter_top albm_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
